FILE: hdl/pnfc_pkg.sv
// Shared types and constants of the parallel NOR flash command machine.
`default_nettype none
package pnfc_pkg;

    localparam int MEM_BYTES    = 524288;   // power of two
    localparam int SECTOR_BYTES = 4096;     // power of two, not above MEM_BYTES
    localparam int BUS_AW       = 19;
    localparam int MEM_AW       = $clog2(MEM_BYTES);

    localparam logic [BUS_AW-1:0] UNLOCK_ADDR1 = 19'h05555;
    localparam logic [BUS_AW-1:0] UNLOCK_ADDR2 = 19'h02aaa;

    localparam logic [7:0] UNLOCK_DATA1     = 8'haa;
    localparam logic [7:0] UNLOCK_DATA2     = 8'h55;
    localparam logic [7:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [7:0] CMD_ID_ENTRY     = 8'h90;
    localparam logic [7:0] CMD_PROGRAM      = 8'ha0;
    localparam logic [7:0] CMD_ID_EXIT      = 8'hf0;
    localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
    localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
    localparam logic [7:0] ERASED_BYTE      = 8'hff;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BUS_AW-1:0] address;
        logic [7:0]        write_data;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       in_id_mode;
    } t_rsp;

    typedef enum logic [2:0] {
        OP_READ         = 3'd0,
        OP_ECHO         = 3'd1,
        OP_PROGRAM      = 3'd2,
        OP_SECTOR_ERASE = 3'd3,
        OP_CHIP_ERASE   = 3'd4
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
        logic              id_mode;
    } t_op;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage
`default_nettype wire

FILE: hdl/parallel_nor_flash_command_machine.sv
// Top level of the byte-wide parallel NOR flash command machine.
// After reset the engine sweeps the whole array to 0xFF, one byte per cycle;
// o_req_ready stays low until that sweep is done. Requests then enter a
// two-entry queue at up to one per cycle while it has room; the unlock
// decoder and ID mode flag live in front of that queue, so command writes are
// classified on intake. The array engine behind it serves one request at a
// time through the single array memory: a write or command is handled as it
// is taken, a read goes through a registered memory read, a byte program is a
// read-modify-write, and a sector or chip erase sweeps that sector or the
// whole array, one byte cleared per cycle. Every request yields one response
// in request order: the stored byte for a read, the write byte echoed for a
// write, with the ID mode flag as it stands after that request. A full output
// register holds the next request back only in the engine.
`default_nettype none
module parallel_nor_flash_command_machine (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_req_valid,
    output logic           o_req_ready,
    input  pnfc_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  wire            i_rsp_ready,
    output pnfc_pkg::t_rsp o_rsp
);
    import pnfc_pkg::*;

    t_back_status w_status;
    t_op          w_push_op, w_pop_op;
    logic         w_push, w_pop, w_full, w_empty;

    // unlock decoder and request intake
    pnfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_req         (i_req),
        .i_back_status (w_status),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_op          (w_push_op)
    );

    // decouples intake from slow array work
    pnfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_op    (w_pop_op),
        .o_empty (w_empty)
    );

    // array memory, program/erase sweeps, response register
    pnfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_pop_op),
        .i_q_empty   (w_empty),
        .o_pop       (w_pop),
        .o_status    (w_status),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire

FILE: hdl/pnfc_front.sv
// Front end: request intake, unlock command decoder and ID mode flag.
`default_nettype none
module pnfc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_req_valid,
    output logic                  o_req_ready,
    input  pnfc_pkg::t_req        i_req,
    input  pnfc_pkg::t_back_status i_back_status,
    input  wire                   i_q_full,
    output logic                  o_push,
    output pnfc_pkg::t_op         o_op
);
    import pnfc_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE        = 7'b0000001,
        PH_GOT_AA      = 7'b0000010,
        PH_GOT_55      = 7'b0000100,
        PH_ERASE_SETUP = 7'b0001000,
        PH_ERASE_AA    = 7'b0010000,
        PH_PROGRAM     = 7'b0100000,
        PH_ERASE_CMD   = 7'b1000000
    } t_phase;

    t_phase r_phase, n_phase;
    logic   r_id, n_id;
    logic   w_accept, w_at1, w_at2;
    logic [7:0] w_d;

    assign o_req_ready = !i_q_full && !i_back_status.clearing;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_at1       = (i_req.address == UNLOCK_ADDR1);
    assign w_at2       = (i_req.address == UNLOCK_ADDR2);
    assign w_d         = i_req.write_data;

    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        o_op.kind = OP_READ;
        o_op.addr = i_req.address[MEM_AW-1:0];
        o_op.data = w_d;
        if (w_accept && i_req.req_type == REQ_WRITE) begin
            n_phase   = PH_IDLE;
            o_op.kind = OP_ECHO;
            case (r_phase)
                PH_IDLE: begin
                    if (w_at1 && w_d == UNLOCK_DATA1) n_phase = PH_GOT_AA;
                    else if (w_d == CMD_ID_EXIT)      n_id = 1'b0;
                end
                PH_GOT_AA: begin
                    if (w_at2 && w_d == UNLOCK_DATA2) n_phase = PH_GOT_55;
                end
                PH_GOT_55: begin
                    if (w_at1) begin
                        if (w_d == CMD_ERASE_SETUP)   n_phase = PH_ERASE_SETUP;
                        else if (w_d == CMD_ID_ENTRY) n_id = 1'b1;
                        else if (w_d == CMD_PROGRAM)  n_phase = PH_PROGRAM;
                        else if (w_d == CMD_ID_EXIT)  n_id = 1'b0;
                    end
                end
                PH_ERASE_SETUP: begin
                    if (w_at1 && w_d == UNLOCK_DATA1) n_phase = PH_ERASE_AA;
                end
                PH_ERASE_AA: begin
                    if (w_at2 && w_d == UNLOCK_DATA2) n_phase = PH_ERASE_CMD;
                end
                PH_PROGRAM: begin
                    o_op.kind = OP_PROGRAM;
                end
                PH_ERASE_CMD: begin
                    if (w_at1 && w_d == CMD_CHIP_ERASE)  o_op.kind = OP_CHIP_ERASE;
                    else if (w_d == CMD_SECTOR_ERASE)    o_op.kind = OP_SECTOR_ERASE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        o_op.id_mode = n_id;
    end

    assign o_push = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_id    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_id    <= n_id;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pnfc_queue.sv
// Two-entry operation queue between the decoder and the array engine.
`default_nettype none
module pnfc_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  pnfc_pkg::t_op i_op,
    output logic          o_full,
    input  wire           i_pop,
    output pnfc_pkg::t_op o_op,
    output logic          o_empty
);
    import pnfc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_op           r_slot [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pnfc_back.sv
// Back end: flash array memory, program and erase engine, response register.
`default_nettype none
module pnfc_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  pnfc_pkg::t_op          i_op,
    input  wire                    i_q_empty,
    output logic                   o_pop,
    output pnfc_pkg::t_back_status o_status,
    output logic                   o_rsp_valid,
    input  wire                    i_rsp_ready,
    output pnfc_pkg::t_rsp         o_rsp
);
    import pnfc_pkg::*;

    localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_BYTES - 1);
    localparam logic [MEM_AW-1:0] SEC_MASK = MEM_AW'(SECTOR_BYTES - 1);

    typedef enum logic [4:0] {
        BS_CLEAR = 5'b00001,
        BS_IDLE  = 5'b00010,
        BS_RDATA = 5'b00100,
        BS_PGM   = 5'b01000,
        BS_SWEEP = 5'b10000
    } t_bstate;

    logic [7:0] r_mem [MEM_BYTES];

    t_bstate           r_state, n_state;
    logic [MEM_AW-1:0] r_cnt, n_cnt, r_last, n_last;
    logic [MEM_AW-1:0] r_op_addr, n_op_addr;
    logic [7:0]        r_op_data, n_op_data;
    logic              r_op_id, n_op_id;
    logic [7:0]        r_rdata;
    t_rsp              r_rsp, n_rsp;
    logic              r_rsp_valid, n_rsp_valid;
    logic              w_slot_free;
    logic              w_we, w_re;
    logic [MEM_AW-1:0] w_wa, w_ra;
    logic [7:0]        w_wd;

    assign w_slot_free = !r_rsp_valid || i_rsp_ready;
    assign o_pop       = (r_state == BS_IDLE) && !i_q_empty && w_slot_free;
    assign o_status.clearing = (r_state == BS_CLEAR);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_op_addr   = r_op_addr;
        n_op_data   = r_op_data;
        n_op_id     = r_op_id;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        w_we        = 1'b0;
        w_wa        = r_cnt;
        w_wd        = ERASED_BYTE;
        w_re        = 1'b0;
        w_ra        = i_op.addr;
        case (r_state)
            BS_CLEAR, BS_SWEEP: begin
                w_we  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ((r_state == BS_CLEAR) ? MEM_LAST : r_last)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (o_pop) begin
                    n_op_addr = i_op.addr;
                    n_op_data = i_op.data;
                    n_op_id   = i_op.id_mode;
                    if (i_op.kind != OP_READ) begin
                        // every write echoes its byte right away
                        n_rsp.read_data  = i_op.data;
                        n_rsp.in_id_mode = i_op.id_mode;
                        n_rsp_valid      = 1'b1;
                    end
                    case (i_op.kind)
                        OP_READ: begin
                            w_re    = 1'b1;
                            n_state = BS_RDATA;
                        end
                        OP_PROGRAM: begin
                            w_re    = 1'b1;
                            n_state = BS_PGM;
                        end
                        OP_SECTOR_ERASE: begin
                            n_cnt   = i_op.addr & ~SEC_MASK;
                            n_last  = i_op.addr | SEC_MASK;
                            n_state = BS_SWEEP;
                        end
                        OP_CHIP_ERASE: begin
                            n_cnt   = '0;
                            n_last  = MEM_LAST;
                            n_state = BS_SWEEP;
                        end
                        default: begin
                            n_state = BS_IDLE;
                        end
                    endcase
                end
            end
            BS_RDATA: begin
                n_rsp.read_data  = r_rdata;
                n_rsp.in_id_mode = r_op_id;
                n_rsp_valid      = 1'b1;
                n_state          = BS_IDLE;
            end
            BS_PGM: begin
                // programming can only clear bits
                w_we    = 1'b1;
                w_wa    = r_op_addr;
                w_wd    = r_rdata & r_op_data;
                n_state = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
    end

    always_ff @(posedge i_clk) begin
        if (w_re) r_rdata <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_op_addr <= n_op_addr;
        r_op_data <= n_op_data;
        r_op_id   <= n_op_id;
        r_rsp     <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pnfc_checker.sv
// Port-level assertions for the flash command machine, bound to the top level.
`default_nettype none
module pnfc_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_req_valid,
    input wire            o_req_ready,
    input pnfc_pkg::t_req i_req,
    input wire            o_rsp_valid,
    input wire            i_rsp_ready,
    input pnfc_pkg::t_rsp o_rsp
);
    import pnfc_pkg::*;

    logic [2:0] r_pending;
    logic       w_req_acc, w_rsp_acc;

    assign w_req_acc = i_req_valid && o_req_ready;
    assign w_rsp_acc = o_rsp_valid && i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {2'b00, w_req_acc} - {2'b00, w_rsp_acc};
        end
    end

    // reset starts the array clearing pass with nothing to deliver
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready && !o_rsp_valid)
        else $error("ready or response valid right after reset");

    // no response without a request still owed one
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> r_pending != 3'd0)
        else $error("response with no outstanding request");

    // at most queue, engine and output register hold requests
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd4)
        else $error("too many outstanding requests");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed or dropped");

    // a waiting request stays put until taken
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_ready |=> i_req_valid && $stable(i_req))
        else $error("stalled request changed or dropped");

endmodule

bind parallel_nor_flash_command_machine pnfc_checker u_pnfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
`default_nettype wire
